// ===== sv/debounced_pin_event_dispatcher_assert.svh =====
// assertion macros for the pin event dispatcher
`ifndef DEBOUNCED_PIN_EVENT_DISPATCHER_ASSERT_SVH
`define DEBOUNCED_PIN_EVENT_DISPATCHER_ASSERT_SVH

// consequent checked in the same cycle
`define DPED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define DPED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dped_pkg.sv =====
// shared types and constants of the pin event dispatcher
`default_nettype none

package dped_pkg;

  localparam int PinCount       = 8;
  localparam int HandlersPerPin = 2;
  localparam int HandlerW       = (HandlersPerPin > 1) ? $clog2(HandlersPerPin) : 1;
  localparam int PinW           = 3;
  localparam int ModeW          = 3;
  localparam int DebW           = 10;
  localparam int PinsPerDebReg  = 4;
  localparam int TimeW          = 32;
  localparam int CfgDataW       = 48;
  localparam int CfgIndexW      = 2;
  localparam int ModesW         = 48;
  localparam int DebRegW        = 40;

  localparam logic [CfgIndexW-1:0] CfgHandlerModes    = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgDebounceLowPins  = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgDebounceHighPins = 2'd2;

  typedef enum logic [1:0] {
    OpPoll    = 2'd0,
    OpEnable  = 2'd1,
    OpDisable = 2'd2
  } op_e;

  typedef enum logic [ModeW-1:0] {
    ModeNone    = 3'd0,
    ModeChange  = 3'd1,
    ModeRising  = 3'd2,
    ModeFalling = 3'd3,
    ModeHigh    = 3'd4,
    ModeLow     = 3'd5
  } mode_e;

  // per-cell command for one accepted request
  typedef struct packed {
    logic             poll;
    logic             enable;
    logic             dis;
    logic             level;
    logic [TimeW-1:0] now;
  } cell_cmd_t;

  // fire record handed down the chain towards cell 0
  typedef struct packed {
    logic                valid;
    logic [PinW-1:0]     pin;
    logic [HandlerW-1:0] hnd;
    logic [ModeW-1:0]    mode;
    logic                more;
  } fire_t;

endpackage

`default_nettype wire

// ===== sv/debounced_pin_event_dispatcher.sv =====
// Debounced pin event dispatcher, top level. A row of eight pin cells holds the
// held level, enable, debounce flag and debounce start time of each pin. An
// accepted poll is evaluated by all cells together; the handler fires it
// causes are then handed down the cell chain in pin order, one fire per cycle
// while the output register is free or being read, into the output register
// through the single drain path of the chain. Enable and disable requests
// cause no fire. A new request is taken once the cells hold no pending fire,
// while the last fire of a poll may still wait in the output register.
// Configuration writes take effect at once and are expected only while the
// block is idle.
`default_nettype none
`include "debounced_pin_event_dispatcher_assert.svh"

module debounced_pin_event_dispatcher (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [1:0]                        operation_i,
  input  wire [7:0]                        pin_levels_i,
  input  wire [dped_pkg::TimeW-1:0]        now_ms_i,
  input  wire [2:0]                        pin_index_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [2:0]                       fired_pin_o,
  output logic [0:0]                       fired_handler_o,
  output logic [2:0]                       fired_mode_o,
  output logic                             last_o,
  input  wire                              cfg_we_i,
  input  wire [dped_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire [dped_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int P  = dped_pkg::PinCount;
  localparam int MW = dped_pkg::ModeW * dped_pkg::HandlersPerPin;

  logic [dped_pkg::ModesW-1:0]   modes_q;
  logic [dped_pkg::DebRegW-1:0]  deb_low_q;
  logic [dped_pkg::DebRegW-1:0]  deb_high_q;

  logic                          out_valid_q;
  logic [2:0]                    pin_q;
  logic [0:0]                    hnd_q;
  logic [2:0]                    mode_q;
  logic                          last_q;

  logic                          accept;
  logic                          op_poll, op_enable, op_disable;
  logic                          busy;
  logic                          load;

  dped_pkg::fire_t               chain [P+1];
  logic                          pop   [P+1];

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    op_poll    = 1'b0;
    op_enable  = 1'b0;
    op_disable = 1'b0;
    unique case (operation_i)
      dped_pkg::OpPoll:    op_poll    = accept;
      dped_pkg::OpEnable:  op_enable  = accept;
      dped_pkg::OpDisable: op_disable = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q    <= '0;
      deb_low_q  <= '0;
      deb_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dped_pkg::CfgHandlerModes:     modes_q    <= cfg_data_i;
        dped_pkg::CfgDebounceLowPins:  deb_low_q  <= cfg_data_i[dped_pkg::DebRegW-1:0];
        dped_pkg::CfgDebounceHighPins: deb_high_q <= cfg_data_i[dped_pkg::DebRegW-1:0];
        default: ;
      endcase
    end
  end

  assign chain[P] = '0;
  assign pop[0]   = load;

  for (genvar p = 0; p < P; p++) begin : g_cell
    dped_pkg::cell_cmd_t           cmd;
    logic [dped_pkg::DebW-1:0]     deb;
    logic                          sel;

    assign sel = pin_index_i == 3'(p);

    if (p < dped_pkg::PinsPerDebReg) begin : g_low
      assign deb = deb_low_q[dped_pkg::DebW*p +: dped_pkg::DebW];
    end else begin : g_high
      assign deb = deb_high_q[dped_pkg::DebW*(p - dped_pkg::PinsPerDebReg) +: dped_pkg::DebW];
    end

    assign cmd.poll   = op_poll;
    assign cmd.enable = op_enable && sel;
    assign cmd.dis    = op_disable && sel;
    assign cmd.level  = pin_levels_i[p];
    assign cmd.now    = now_ms_i;

    dped_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .pin_i      (3'(p)),
      .debounce_i (deb),
      .modes_i    (modes_q[MW*p +: MW]),
      .chain_i    (chain[p+1]),
      .chain_o    (chain[p]),
      .pop_i      (pop[p]),
      .pop_o      (pop[p+1])
    );
  end

  assign busy       = chain[0].valid;
  assign load       = busy && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pin_q  <= chain[0].pin;
      hnd_q  <= 1'(chain[0].hnd);
      mode_q <= chain[0].mode;
      last_q <= !chain[0].more;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fired_pin_o     = pin_q;
  assign fired_handler_o = hnd_q;
  assign fired_mode_o    = mode_q;
  assign last_o          = last_q;

  `DPED_ASSERT_NOW(a_more_pending, out_valid_o && !last_o, !in_ready_o,
                   "non-final fire shown while cells report no pending fire")
  `DPED_ASSERT_NEXT(a_drain_fills, busy && !out_valid_q, out_valid_q,
                    "pending fire not moved into empty output register")
  `DPED_ASSERT_NEXT(a_cmd_no_fire,
                    accept && operation_i != dped_pkg::OpPoll, in_ready_o,
                    "enable or disable request left fires pending")

endmodule

`default_nettype wire

// ===== sv/dped_cell.sv =====
// one pin cell: debounce state, pending fires and chain links
`default_nettype none

module dped_cell (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  input  dped_pkg::cell_cmd_t                                  cmd_i,
  input  wire [dped_pkg::PinW-1:0]                             pin_i,
  input  wire [dped_pkg::DebW-1:0]                             debounce_i,
  input  wire [dped_pkg::ModeW*dped_pkg::HandlersPerPin-1:0]   modes_i,
  input  dped_pkg::fire_t                                      chain_i,
  output dped_pkg::fire_t                                      chain_o,
  input  wire                                                  pop_i,
  output logic                                                 pop_o
);

  localparam int H = dped_pkg::HandlersPerPin;

  logic                           held_q, held_d;
  logic                           en_q, en_d;
  logic                           deb_q, deb_d;
  logic [dped_pkg::TimeW-1:0]     start_q, start_d;
  logic [H-1:0]                   pa_q, pa_d;
  logic [H-1:0]                   pl_q, pl_d;

  logic [dped_pkg::TimeW-1:0]     elapsed;
  logic                           expire;
  logic                           acc;
  logic                           has;
  logic                           in_pa;
  logic [dped_pkg::HandlerW-1:0]  first;
  logic [dped_pkg::ModeW-1:0]     first_mode;
  logic [H-1:0]                   pa_n, pl_n;
  logic [H-1:0]                   fa, fl;
  logic [dped_pkg::ModeW-1:0]     m;

  assign elapsed = cmd_i.now - start_q;
  assign expire  = elapsed >= dped_pkg::TimeW'(debounce_i);
  assign has     = (|pa_q) || (|pl_q);

  // earliest pending fire: change-type handlers before level handlers
  always_comb begin
    first = '0;
    in_pa = |pa_q;
    for (int k = H - 1; k >= 0; k--) begin
      if (in_pa ? pa_q[k] : pl_q[k]) begin
        first = dped_pkg::HandlerW'(k);
      end
    end
    pa_n = pa_q;
    pl_n = pl_q;
    first_mode = '0;
    for (int k = 0; k < H; k++) begin
      if (first == dped_pkg::HandlerW'(k)) begin
        first_mode = modes_i[dped_pkg::ModeW*k +: dped_pkg::ModeW];
        if (in_pa) begin
          pa_n[k] = 1'b0;
        end else begin
          pl_n[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (has) begin
      chain_o.valid = 1'b1;
      chain_o.pin   = pin_i;
      chain_o.hnd   = first;
      chain_o.mode  = first_mode;
      chain_o.more  = (|pa_n) || (|pl_n) || chain_i.valid;
    end else begin
      chain_o = chain_i;
    end
  end

  assign pop_o = pop_i && !has;

  always_comb begin
    held_d  = held_q;
    en_d    = en_q;
    deb_d   = deb_q;
    start_d = start_q;
    pa_d    = pa_q;
    pl_d    = pl_q;
    acc     = 1'b0;
    fa      = '0;
    fl      = '0;
    m       = '0;
    if (pop_i && has) begin
      pa_d = pa_n;
      pl_d = pl_n;
    end
    if (cmd_i.enable) begin
      held_d = cmd_i.level;
      en_d   = 1'b1;
    end
    if (cmd_i.dis) begin
      en_d = 1'b0;
    end
    if (cmd_i.poll && en_q) begin
      if (deb_q) begin
        if (expire) begin
          if (cmd_i.level != held_q) begin
            held_d = ~held_q;
            acc    = 1'b1;
          end
          deb_d = 1'b0;
        end
      end else if (cmd_i.level != held_q) begin
        if (debounce_i != '0) begin
          start_d = cmd_i.now;
          deb_d   = 1'b1;
        end else begin
          held_d = ~held_q;
          acc    = 1'b1;
        end
      end
      for (int k = 0; k < H; k++) begin
        m     = modes_i[dped_pkg::ModeW*k +: dped_pkg::ModeW];
        fa[k] = acc && ((m == dped_pkg::ModeChange) ||
                        (m == dped_pkg::ModeRising && held_d) ||
                        (m == dped_pkg::ModeFalling && !held_d));
        fl[k] = (m == dped_pkg::ModeHigh && held_d) ||
                (m == dped_pkg::ModeLow && !held_d);
      end
      pa_d = fa;
      pl_d = fl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      en_q    <= 1'b1;
      deb_q   <= 1'b0;
      start_q <= '0;
      pa_q    <= '0;
      pl_q    <= '0;
    end else begin
      held_q  <= held_d;
      en_q    <= en_d;
      deb_q   <= deb_d;
      start_q <= start_d;
      pa_q    <= pa_d;
      pl_q    <= pl_d;
    end
  end

endmodule

`default_nettype wire
